@@ sv/fcs_pkg.sv @@
`default_nettype none

package fcs_pkg;

    localparam logic [7:0] CMD_DEVICE_ID = 8'h00;
    localparam logic [7:0] CMD_IRQ_ENABLE = 8'h81;
    localparam logic [7:0] CMD_READ_STATUS = 8'h83;
    localparam logic [7:0] CMD_READ_ID = 8'h85;
    localparam logic [7:0] CMD_CLEAR_STATUS = 8'h89;
    localparam logic [7:0] CMD_ARRAY_READ = 8'h52;
    localparam logic [7:0] CMD_SECTOR_ERASE = 8'hF1;
    localparam logic [7:0] CMD_PAGE_PROGRAM = 8'hF2;
    localparam logic [7:0] CMD_CHIP_ERASE = 8'hF4;

    localparam logic [7:0] READ_ID_BYTE1 = 8'h80;
    localparam logic [7:0] READ_ID_BYTE2 = 8'hC2;
    localparam logic [7:0] READ_ID_BYTE3 = 8'h21;
    localparam logic [7:0] READ_ID_TAIL = 8'h00;

    localparam logic [7:0] IDLE_BYTE = 8'hFF;
    localparam logic [7:0] ERASED_BYTE = 8'hFF;
    localparam logic [7:0] STATUS_RESET = 8'h41;
    localparam logic [7:0] STATUS_CLEAR_MASK = 8'h18;
    localparam logic [31:0] DEVICE_ID_RESET = 32'd4;

    localparam logic [3:0] POS_MAX = 4'd15;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_DEVICE_ID,
        OP_CONST,
        OP_STATUS,
        OP_IRQ_ENABLE,
        OP_READ,
        OP_PROGRAM,
        OP_SECTOR_ERASE,
        OP_CHIP_ERASE,
        OP_END,
        OP_END_WRITE
    } fcs_op_t;

    typedef struct packed {
        fcs_op_t    op;
        logic [7:0] data;
        logic [1:0] idx;
    } fcs_item_t;

endpackage

`default_nettype wire

@@ sv/fcs_front.sv @@
`default_nettype none

module fcs_front #(
    parameter int CARD_SIZE_BYTES = 524288
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               cmd,
    input  wire logic [7:0]                         byte_in,
    input  wire logic                               q_full,
    input  wire logic                               clearing,
    output logic                                    push,
    output fcs_pkg::fcs_item_t                      push_item,
    output logic [$clog2(CARD_SIZE_BYTES)-1:0]      push_addr
);

    import fcs_pkg::*;

    localparam int AW = $clog2(CARD_SIZE_BYTES);

    logic [3:0]    pos_reg, pos_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic [1:0]    idx_reg, idx_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [24:0]   addr_wide;
    logic [24:0]   addr_calc;

    assign in_stall = q_full || clearing;
    assign push = in_valid && !in_stall;
    assign addr_wide = {{(25 - AW){1'b0}}, addr_reg};

    always_comb
    begin
        unique case (pos_reg)
            4'd1: addr_calc = {byte_in, 17'd0};
            4'd2: addr_calc = addr_wide | {8'd0, byte_in, 9'd0};
            4'd3: addr_calc = addr_wide | {16'd0, byte_in[1:0], 7'd0};
            4'd4: addr_calc = addr_wide | {18'd0, byte_in[6:0]};
            default: addr_calc = addr_wide;
        endcase
    end

    always_comb
    begin
        pos_next = pos_reg;
        cmd_next = cmd_reg;
        idx_next = idx_reg;
        addr_next = addr_reg;
        push_item.op = OP_NOP;
        push_item.data = byte_in;
        push_item.idx = idx_reg;
        push_addr = addr_reg;

        if (cmd)
        begin
            pos_next = 4'd0;
            idx_next = 2'd0;
            if (cmd_reg == CMD_SECTOR_ERASE || cmd_reg == CMD_PAGE_PROGRAM ||
                cmd_reg == CMD_CHIP_ERASE)
            begin
                push_item.op = OP_END_WRITE;
            end
            else
            begin
                push_item.op = OP_END;
            end
        end
        else if (pos_reg == 4'd0)
        begin
            cmd_next = byte_in;
            idx_next = 2'd0;
            pos_next = 4'd1;
            if (byte_in == CMD_CLEAR_STATUS)
            begin
                push_item.op = OP_CLEAR;
            end
        end
        else
        begin
            if (pos_reg < POS_MAX)
            begin
                pos_next = pos_reg + 4'd1;
            end
            unique case (cmd_reg)
                CMD_DEVICE_ID:
                begin
                    if (pos_reg >= 4'd2)
                    begin
                        push_item.op = OP_DEVICE_ID;
                        idx_next = idx_reg + 2'd1;
                    end
                end
                CMD_READ_ID:
                begin
                    push_item.op = OP_CONST;
                    unique case (pos_reg)
                        4'd1: push_item.data = READ_ID_BYTE1;
                        4'd2: push_item.data = READ_ID_BYTE2;
                        4'd3: push_item.data = READ_ID_BYTE3;
                        default: push_item.data = READ_ID_TAIL;
                    endcase
                end
                CMD_READ_STATUS:
                begin
                    push_item.op = OP_STATUS;
                end
                CMD_ARRAY_READ:
                begin
                    if (pos_reg <= 4'd4)
                    begin
                        addr_next = addr_calc[AW-1:0];
                    end
                    else if (pos_reg >= 4'd9)
                    begin
                        push_item.op = OP_READ;
                        addr_next = addr_reg + AW'(1);
                    end
                end
                CMD_PAGE_PROGRAM:
                begin
                    if (pos_reg <= 4'd4)
                    begin
                        addr_next = addr_calc[AW-1:0];
                    end
                    else
                    begin
                        push_item.op = OP_PROGRAM;
                        addr_next = addr_reg + AW'(1);
                    end
                end
                CMD_SECTOR_ERASE:
                begin
                    if (pos_reg == 4'd1)
                    begin
                        addr_next = addr_calc[AW-1:0];
                    end
                    else if (pos_reg == 4'd2)
                    begin
                        addr_next = addr_calc[AW-1:0];
                        push_addr = addr_calc[AW-1:0];
                        push_item.op = OP_SECTOR_ERASE;
                    end
                end
                CMD_CHIP_ERASE:
                begin
                    if (pos_reg == 4'd2)
                    begin
                        push_item.op = OP_CHIP_ERASE;
                    end
                end
                CMD_IRQ_ENABLE:
                begin
                    if (pos_reg == 4'd1)
                    begin
                        push_item.op = OP_IRQ_ENABLE;
                    end
                end
                default:
                begin
                    push_item.op = OP_NOP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 4'd0;
            cmd_reg <= 8'd0;
            idx_reg <= 2'd0;
            addr_reg <= '0;
        end
        else if (push)
        begin
            pos_reg <= pos_next;
            cmd_reg <= cmd_next;
            idx_reg <= idx_next;
            addr_reg <= addr_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/fcs_queue.sv @@
`default_nettype none

module fcs_queue #(
    parameter int CARD_SIZE_BYTES = 524288
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   push,
    input  wire fcs_pkg::fcs_item_t                     push_item,
    input  wire logic [$clog2(CARD_SIZE_BYTES)-1:0]     push_addr,
    output logic                                        full,
    input  wire logic                                   pop,
    output logic                                        valid,
    output fcs_pkg::fcs_item_t                          item,
    output logic [$clog2(CARD_SIZE_BYTES)-1:0]          addr
);

    import fcs_pkg::*;

    localparam int AW = $clog2(CARD_SIZE_BYTES);
    localparam int DEPTH = 2;
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    fcs_item_t     item_mem [DEPTH];
    logic [AW-1:0] addr_mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full = count_reg == CW'(DEPTH);
    assign valid = count_reg != '0;
    assign item = item_mem[rd_ptr_reg];
    assign addr = addr_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_mem[wr_ptr_reg] <= push_item;
            addr_mem[wr_ptr_reg] <= push_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/fcs_back.sv @@
`default_nettype none

module fcs_back #(
    parameter int CARD_SIZE_BYTES = 524288,
    parameter int SECTOR_SIZE_BYTES = 8192
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   q_valid,
    input  wire fcs_pkg::fcs_item_t                     q_item,
    input  wire logic [$clog2(CARD_SIZE_BYTES)-1:0]     q_addr,
    output logic                                        q_pop,
    input  wire logic [31:0]                            device_id,
    output logic                                        clearing,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [7:0]                                  byte_out,
    output logic                                        interrupt_line,
    output logic                                        interrupt_raised
);

    import fcs_pkg::*;

    localparam int AW = $clog2(CARD_SIZE_BYTES);
    localparam logic [AW-1:0] SECTOR_MASK = AW'(SECTOR_SIZE_BYTES - 1);
    localparam logic [AW-1:0] CHIP_MASK = AW'(CARD_SIZE_BYTES - 1);

    typedef enum logic [4:0] {
        B_INIT  = 5'b00001,
        B_IDLE  = 5'b00010,
        B_READ  = 5'b00100,
        B_PROG  = 5'b01000,
        B_SWEEP = 5'b10000
    } back_state_t;

    back_state_t   state_reg, state_next;
    logic [7:0]    status_reg, status_next;
    logic          ien_reg, ien_next;
    logic          irq_reg, irq_next;
    logic [7:0]    byte_reg, byte_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic          sweep_chip_reg, sweep_chip_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_irq_reg, out_irq_next;
    logic          out_raised_reg, out_raised_next;

    logic [7:0]    flash_mem [CARD_SIZE_BYTES];
    logic [7:0]    rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    logic          out_free;
    logic          out_load;
    logic [7:0]    load_byte;
    logic          load_raised;
    logic [AW-1:0] sweep_mask;
    logic          sweep_last;
    logic [7:0]    id_byte;

    assign out_free = !out_valid_reg || !out_stall;
    assign sweep_mask = sweep_chip_reg ? CHIP_MASK : SECTOR_MASK;
    assign sweep_last = (sweep_cnt_reg & sweep_mask) == sweep_mask;
    assign clearing = state_reg == B_INIT;

    always_comb
    begin
        unique case (q_item.idx)
            2'd0: id_byte = device_id[31:24];
            2'd1: id_byte = device_id[23:16];
            2'd2: id_byte = device_id[15:8];
            default: id_byte = device_id[7:0];
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        status_next = status_reg;
        ien_next = ien_reg;
        irq_next = irq_reg;
        byte_next = byte_reg;
        addr_next = addr_reg;
        sweep_cnt_next = sweep_cnt_reg;
        sweep_chip_next = sweep_chip_reg;
        q_pop = 1'b0;
        mem_we = 1'b0;
        mem_waddr = sweep_cnt_reg;
        mem_wdata = ERASED_BYTE;
        out_load = 1'b0;
        load_byte = IDLE_BYTE;
        load_raised = 1'b0;

        unique case (state_reg)
            B_INIT, B_SWEEP:
            begin
                mem_we = 1'b1;
                if (sweep_last)
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    sweep_cnt_next = sweep_cnt_reg + AW'(1);
                end
            end
            B_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    addr_next = q_addr;
                    byte_next = q_item.data;
                    unique case (q_item.op)
                        OP_NOP, OP_END:
                        begin
                            out_load = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            status_next = status_reg & ~STATUS_CLEAR_MASK;
                            irq_next = 1'b0;
                            out_load = 1'b1;
                        end
                        OP_DEVICE_ID:
                        begin
                            load_byte = id_byte;
                            out_load = 1'b1;
                        end
                        OP_CONST:
                        begin
                            load_byte = q_item.data;
                            out_load = 1'b1;
                        end
                        OP_STATUS:
                        begin
                            load_byte = status_reg;
                            out_load = 1'b1;
                        end
                        OP_IRQ_ENABLE:
                        begin
                            ien_next = q_item.data[0];
                            out_load = 1'b1;
                        end
                        OP_READ:
                        begin
                            state_next = B_READ;
                        end
                        OP_PROGRAM:
                        begin
                            state_next = B_PROG;
                        end
                        OP_SECTOR_ERASE:
                        begin
                            sweep_cnt_next = q_addr & ~SECTOR_MASK;
                            sweep_chip_next = 1'b0;
                            state_next = B_SWEEP;
                            out_load = 1'b1;
                        end
                        OP_CHIP_ERASE:
                        begin
                            sweep_cnt_next = '0;
                            sweep_chip_next = 1'b1;
                            state_next = B_SWEEP;
                            out_load = 1'b1;
                        end
                        OP_END_WRITE:
                        begin
                            if (ien_reg && !irq_reg)
                            begin
                                irq_next = 1'b1;
                                load_raised = 1'b1;
                            end
                            out_load = 1'b1;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            B_READ:
            begin
                load_byte = rdata_reg;
                out_load = 1'b1;
                state_next = B_IDLE;
            end
            B_PROG:
            begin
                mem_we = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = rdata_reg & byte_reg;
                out_load = 1'b1;
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && out_stall;
        out_byte_next = out_byte_reg;
        out_irq_next = out_irq_reg;
        out_raised_next = out_raised_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_byte_next = load_byte;
            out_irq_next = irq_next;
            out_raised_next = load_raised;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            flash_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= flash_mem[q_addr];
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        addr_reg <= addr_next;
        out_byte_reg <= out_byte_next;
        out_irq_reg <= out_irq_next;
        out_raised_reg <= out_raised_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_INIT;
            status_reg <= STATUS_RESET;
            ien_reg <= 1'b0;
            irq_reg <= 1'b0;
            sweep_cnt_reg <= '0;
            sweep_chip_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            status_reg <= status_next;
            ien_reg <= ien_next;
            irq_reg <= irq_next;
            sweep_cnt_reg <= sweep_cnt_next;
            sweep_chip_reg <= sweep_chip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign byte_out = out_byte_reg;
    assign interrupt_line = out_irq_reg;
    assign interrupt_raised = out_raised_reg;

endmodule

`default_nettype wire

@@ sv/flash_card_serial_command_device_top.sv @@
// Channel    Direction  Handshake            Payload
// input      in         in_valid, in_stall   cmd, byte_in
// output     out        out_valid, out_stall byte_out, interrupt_line, interrupt_raised
// config     in         cfg_we               cfg_wdata (device ID word)
//
// Array read and page program pass through an extra back-end state (B_READ or B_PROG),
// as the read port of the flash memory is registered.
// A sector erase sweeps SECTOR_SIZE_BYTES bytes and a chip erase CARD_SIZE_BYTES bytes,
// one memory write per cycle, while the back end takes no items from the queue.
// After reset a clearing pass fills all CARD_SIZE_BYTES bytes of memory with 0xFF, and
// in_stall is high throughout it.
// A two-entry queue separates the front end from the back end, so input keeps flowing
// until the queue fills while a result waits in the output register.
`default_nettype none

module flash_card_serial_command_device_top #(
    parameter int CARD_SIZE_BYTES = 524288,
    parameter int SECTOR_SIZE_BYTES = 8192
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [7:0]  byte_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       byte_out,
    output logic             interrupt_line,
    output logic             interrupt_raised
);

    import fcs_pkg::*;

    localparam int AW = $clog2(CARD_SIZE_BYTES);

    logic [31:0]   device_id_reg;
    logic          push;
    fcs_item_t     push_item;
    logic [AW-1:0] push_addr;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    fcs_item_t     q_item;
    logic [AW-1:0] q_addr;
    logic          clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg <= DEVICE_ID_RESET;
        end
        else if (cfg_we)
        begin
            device_id_reg <= cfg_wdata;
        end
    end

    fcs_front #(
        .CARD_SIZE_BYTES(CARD_SIZE_BYTES)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .byte_in(byte_in),
        .q_full(q_full),
        .clearing(clearing),
        .push(push),
        .push_item(push_item),
        .push_addr(push_addr)
    );

    fcs_queue #(
        .CARD_SIZE_BYTES(CARD_SIZE_BYTES)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_item(push_item),
        .push_addr(push_addr),
        .full(q_full),
        .pop(q_pop),
        .valid(q_valid),
        .item(q_item),
        .addr(q_addr)
    );

    fcs_back #(
        .CARD_SIZE_BYTES(CARD_SIZE_BYTES),
        .SECTOR_SIZE_BYTES(SECTOR_SIZE_BYTES)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_valid(q_valid),
        .q_item(q_item),
        .q_addr(q_addr),
        .q_pop(q_pop),
        .device_id(device_id_reg),
        .clearing(clearing),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .byte_out(byte_out),
        .interrupt_line(interrupt_line),
        .interrupt_raised(interrupt_raised)
    );

    a_raised_sets_line: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && interrupt_raised) |-> interrupt_line)
        else $error("interrupt raised without the line set");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_pop)
        else $error("queue popped during the clearing pass");

    a_no_push_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |=> !$past(push))
        else $error("item taken during the clearing pass");

endmodule

`default_nettype wire

@@ tb/tb_flash_card_serial_command_device_top.sv @@
`timescale 1ns / 1ps

module tb_flash_card_serial_command_device_top;

    import fcs_pkg::*;

    localparam int SECTOR_BYTES = 8192;
    localparam int SETTLE_CYCLES = 32;
    localparam int ITEMS_PER_PHASE = 325;

    localparam logic [7:0] CMD_UNUSED_86 = 8'h86;
    localparam logic [7:0] CMD_UNUSED_87 = 8'h87;
    localparam logic [7:0] CMD_UNUSED_88 = 8'h88;

    typedef struct packed {
        logic       end_frame;
        logic [7:0] data;
    } card_item_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       line;
        logic       raised;
    } card_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = 32'd0;
    logic        in_valid = 1'b0;
    logic        cmd = 1'b0;
    logic [7:0]  byte_in = 8'd0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [7:0]  byte_out;
    logic        interrupt_line;
    logic        interrupt_raised;

    card_item_t  pending_items[$];
    card_reply_t expected_replies[$];
    card_item_t  next_item;
    card_reply_t oldest_reply;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatch_count = 0;
    logic [18:0] hot_addr[4];

    logic [7:0]  flash_contents[int];
    logic [3:0]  frame_pos = 4'd0;
    logic [1:0]  id_index = 2'd0;
    logic [7:0]  active_cmd = CMD_DEVICE_ID;
    logic [18:0] card_addr = 19'd0;
    logic [7:0]  status_reg = STATUS_RESET;
    logic        irq_enable = 1'b0;
    logic        irq_pending = 1'b0;
    logic [31:0] device_id = DEVICE_ID_RESET;

    flash_card_serial_command_device_top u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .byte_in          (byte_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .byte_out         (byte_out),
        .interrupt_line   (interrupt_line),
        .interrupt_raised (interrupt_raised)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [7:0] flash_byte(input logic [18:0] a);
        return flash_contents.exists(int'(a)) ? flash_contents[int'(a)] : ERASED_BYTE;
    endfunction

    function automatic void latch_address_byte(input logic [7:0] b);
        if (frame_pos == 4'd1)
            card_addr = {b[1:0], 17'd0};
        else if (frame_pos == 4'd2)
            card_addr = card_addr | {2'd0, b, 9'd0};
        else if (frame_pos == 4'd3)
            card_addr = card_addr | {10'd0, b[1:0], 7'd0};
        else if (frame_pos == 4'd4)
            card_addr = card_addr | {12'd0, b[6:0]};
    endfunction

    function automatic card_reply_t flash_card_step(input logic end_frame, input logic [7:0] b);
        card_reply_t r;
        int          base;
        int          k;
        r.byte_out = IDLE_BYTE;
        r.raised = 1'b0;
        if (end_frame)
        begin
            if ((active_cmd == CMD_SECTOR_ERASE || active_cmd == CMD_PAGE_PROGRAM ||
                 active_cmd == CMD_CHIP_ERASE) && irq_enable && !irq_pending)
            begin
                irq_pending = 1'b1;
                r.raised = 1'b1;
            end
            frame_pos = 4'd0;
            id_index = 2'd0;
        end
        else if (frame_pos == 4'd0)
        begin
            active_cmd = b;
            id_index = 2'd0;
            if (b == CMD_CLEAR_STATUS)
            begin
                status_reg = status_reg & ~STATUS_CLEAR_MASK;
                irq_pending = 1'b0;
            end
            frame_pos = 4'd1;
        end
        else
        begin
            case (active_cmd)
                CMD_DEVICE_ID:
                    if (frame_pos >= 4'd2)
                    begin
                        r.byte_out = 8'(device_id >> (8 * (3 - int'(id_index))));
                        id_index = id_index + 2'd1;
                    end
                CMD_READ_ID:
                    r.byte_out = (frame_pos == 4'd1) ? READ_ID_BYTE1 :
                                 (frame_pos == 4'd2) ? READ_ID_BYTE2 :
                                 (frame_pos == 4'd3) ? READ_ID_BYTE3 : READ_ID_TAIL;
                CMD_READ_STATUS:
                    r.byte_out = status_reg;
                CMD_ARRAY_READ:
                    if (frame_pos <= 4'd4)
                        latch_address_byte(b);
                    else if (frame_pos >= 4'd9)
                    begin
                        r.byte_out = flash_byte(card_addr);
                        card_addr = card_addr + 19'd1;
                    end
                CMD_PAGE_PROGRAM:
                    if (frame_pos <= 4'd4)
                        latch_address_byte(b);
                    else
                    begin
                        flash_contents[int'(card_addr)] = flash_byte(card_addr) & b;
                        card_addr = card_addr + 19'd1;
                    end
                CMD_SECTOR_ERASE:
                    if (frame_pos == 4'd1)
                        card_addr = {b[1:0], 17'd0};
                    else if (frame_pos == 4'd2)
                    begin
                        card_addr = card_addr | {2'd0, b, 9'd0};
                        base = int'({card_addr[18:13], 13'd0});
                        for (k = 0; k < SECTOR_BYTES; k++)
                            flash_contents.delete(base + k);
                    end
                CMD_CHIP_ERASE:
                    if (frame_pos == 4'd2)
                        flash_contents.delete();
                CMD_IRQ_ENABLE:
                    if (frame_pos == 4'd1)
                        irq_enable = b[0];
                default:
                    ;
            endcase
            if (frame_pos != POS_MAX)
                frame_pos = frame_pos + 4'd1;
        end
        r.line = irq_pending;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_replies.push_back(flash_card_step(cmd, byte_in));
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    cmd <= next_item.end_frame;
                    byte_in <= next_item.data;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %02h, got %02h", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_replies.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with no item outstanding, byte %02h",
                                 $time, byte_out);
                end
                else
                begin
                    oldest_reply = expected_replies.pop_front();
                    if (byte_out !== oldest_reply.byte_out)
                        report_mismatch("byte_out", oldest_reply.byte_out, byte_out);
                    if (interrupt_line !== oldest_reply.line)
                        report_mismatch("interrupt_line", 8'(oldest_reply.line),
                                        8'(interrupt_line));
                    if (interrupt_raised !== oldest_reply.raised)
                        report_mismatch("interrupt_raised", 8'(oldest_reply.raised),
                                        8'(interrupt_raised));
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    function automatic void push_byte(input logic [7:0] b);
        pending_items.push_back('{end_frame: 1'b0, data: b});
    endfunction

    function automatic void push_end();
        pending_items.push_back('{end_frame: 1'b1, data: 8'($urandom)});
    endfunction

    function automatic void push_random_bytes(input int n);
        repeat (n) push_byte(8'($urandom));
    endfunction

    function automatic void push_address(input logic [18:0] a, input int n);
        push_byte({6'($urandom), a[18:17]});
        if (n > 1)
            push_byte(a[16:9]);
        if (n > 2)
            push_byte({6'($urandom), a[8:7]});
        if (n > 3)
            push_byte({1'($urandom), a[6:0]});
    endfunction

    function automatic logic [18:0] pick_address();
        if ($urandom_range(0, 99) < 70)
            return hot_addr[$urandom_range(0, 3)] + 19'($urandom_range(0, 15));
        return 19'($urandom);
    endfunction

    function automatic logic is_known_cmd(input logic [7:0] c);
        return c == CMD_DEVICE_ID || c == CMD_IRQ_ENABLE || c == CMD_READ_STATUS ||
               c == CMD_READ_ID || c == CMD_CLEAR_STATUS || c == CMD_ARRAY_READ ||
               c == CMD_SECTOR_ERASE || c == CMD_PAGE_PROGRAM || c == CMD_CHIP_ERASE;
    endfunction

    function automatic void queue_directed_frames();
        push_byte(CMD_IRQ_ENABLE);
        push_byte(8'hFF);
        push_end();
        push_byte(CMD_PAGE_PROGRAM);
        push_address(19'h7FFFF, 4);
        push_byte(8'h00);
        push_byte(8'hA5);
        push_end();
        push_end();
        push_byte(CMD_CLEAR_STATUS);
        push_end();
        push_byte(CMD_CHIP_ERASE);
        push_byte(8'h00);
        push_byte(8'h00);
        push_end();
        push_byte(CMD_DEVICE_ID);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_random_bytes(4);
        push_end();
        push_byte(CMD_READ_ID);
        push_random_bytes(4);
        push_end();
    endfunction

    function automatic void queue_random_frames(input int n_items);
        int          start_size;
        int          kind;
        int          erase_budget;
        logic [7:0]  c;
        start_size = pending_items.size();
        erase_budget = 3;
        while (pending_items.size() - start_size < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 20)
            begin
                push_byte(CMD_PAGE_PROGRAM);
                push_address(pick_address(), 4);
                push_random_bytes($urandom_range(1, 8));
            end
            else if (kind < 40)
            begin
                push_byte(CMD_ARRAY_READ);
                push_address(pick_address(), 4);
                push_random_bytes(4);
                push_random_bytes(($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) :
                                  $urandom_range(1, 9));
            end
            else if (kind < 48)
            begin
                push_byte(CMD_DEVICE_ID);
                push_random_bytes($urandom_range(0, 9));
            end
            else if (kind < 54)
            begin
                push_byte(CMD_READ_ID);
                push_random_bytes($urandom_range(0, 6));
            end
            else if (kind < 60)
            begin
                push_byte(CMD_READ_STATUS);
                push_random_bytes($urandom_range(0, 3));
            end
            else if (kind < 68)
            begin
                push_byte(CMD_CLEAR_STATUS);
                push_random_bytes($urandom_range(0, 2));
            end
            else if (kind < 76)
            begin
                push_byte(CMD_IRQ_ENABLE);
                push_byte({7'($urandom), 1'($urandom_range(0, 99) < 70)});
                push_random_bytes($urandom_range(0, 1));
            end
            else if (kind < 79 && erase_budget > 0)
            begin
                erase_budget--;
                push_byte(CMD_SECTOR_ERASE);
                push_address(pick_address(), 2);
                push_random_bytes($urandom_range(0, 2));
            end
            else if (kind < 83)
            begin
                push_byte(CMD_CHIP_ERASE);
                push_random_bytes($urandom_range(0, 1));
            end
            else if (kind < 88)
            begin
                push_byte($urandom_range(0, 1) ? CMD_PAGE_PROGRAM : CMD_ARRAY_READ);
                push_address(pick_address(), $urandom_range(1, 3));
            end
            else if (kind < 94)
            begin
                case ($urandom_range(0, 3))
                    0: c = CMD_UNUSED_86;
                    1: c = CMD_UNUSED_87;
                    2: c = CMD_UNUSED_88;
                    default:
                    begin
                        c = 8'($urandom);
                        if (is_known_cmd(c))
                            c = CMD_UNUSED_86;
                    end
                endcase
                push_byte(c);
                push_random_bytes($urandom_range(0, 4));
            end
            else if (kind < 97)
            begin
                push_random_bytes(1);
                push_random_bytes($urandom_range(0, 1));
            end
            push_end();
        end
    endfunction

    task automatic wait_card_idle();
        while (pending_items.size() != 0 || in_valid || expected_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_device_id(input logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        device_id = value;
    endtask

    initial
    begin
        hot_addr[0] = 19'd0;
        hot_addr[1] = 19'h7FFFA;
        hot_addr[2] = 19'($urandom);
        hot_addr[3] = 19'($urandom);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_card_idle();
            case (phase)
                0: write_device_id(32'hFFFF_FFFF);
                1: write_device_id(32'h0000_0000);
                default: write_device_id($urandom);
            endcase
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 79;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 79;
                end
                default:
                begin
                    send_idle_pct = 14;
                    recv_stall_pct = 14;
                end
            endcase
            if (phase == 0)
                queue_directed_frames();
            queue_random_frames(ITEMS_PER_PHASE);
        end
        wait_card_idle();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/fcs_pkg.sv
sv/fcs_front.sv
sv/fcs_queue.sv
sv/fcs_back.sv
sv/flash_card_serial_command_device_top.sv
tb/tb_flash_card_serial_command_device_top.sv
